FILE: src/trimmed_mean_range_sensor_filter_defines.svh
// Assertion macros for the range sensor filter modules; only tmrs_back uses them.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef TRIMMED_MEAN_RANGE_SENSOR_FILTER_DEFINES_SVH
`define TRIMMED_MEAN_RANGE_SENSOR_FILTER_DEFINES_SVH

// same-cycle implication
`define TMRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TMRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/tmrs_pkg.sv
// Shared constants, types and state encodings of the range sensor filter.
// No dependencies; every module file imports it.
package tmrs_pkg;

    localparam int SENSOR_COUNT  = 4;
    localparam int SAMPLE_COUNT  = 7;
    localparam int SAMPLE_BITS   = 10;

    localparam int IDX_BITS      = 2;
    localparam int NUM_BITS      = 20;
    localparam int OFF_BITS      = 14;
    localparam int SCNT_BITS     = 3;
    localparam int WGT_BITS      = 4;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 20;

    localparam int MID_LOW       = (SAMPLE_COUNT - 3) / 2;
    localparam int SUM3_BITS     = SAMPLE_BITS + 2;
    localparam int DIV3_MUL      = 43691;
    localparam int DIV3_SHIFT    = 17;
    localparam int BLEND_BITS    = SAMPLE_BITS + 4;
    localparam int DIV10_MUL     = 52429;
    localparam int DIV10_SHIFT   = 19;
    localparam int DIVW          = SAMPLE_BITS + 4;
    localparam int DEN_BITS      = ((DIVW > OFF_BITS) ? DIVW : OFF_BITS) + 1;

    localparam int STORE_IDX_BITS = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);
    localparam int SORT_CNT_BITS = $clog2(SAMPLE_COUNT);
    localparam int DIV_CNT_BITS  = $clog2(NUM_BITS);

    localparam int S_DATA_BITS   = ((SAMPLE_COUNT * SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS   = ((NUM_BITS + SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_USER_BITS   = IDX_BITS + 1;

    localparam logic [WGT_BITS-1:0] WEIGHT_FULL = WGT_BITS'(10);

    localparam logic [CFG_ADDR_BITS-1:0] CFG_SIDE_NUM   = CFG_ADDR_BITS'(0);
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SIDE_OFF   = CFG_ADDR_BITS'(1);
    localparam logic [CFG_ADDR_BITS-1:0] CFG_FRONT_NUM  = CFG_ADDR_BITS'(2);
    localparam logic [CFG_ADDR_BITS-1:0] CFG_FRONT_OFF  = CFG_ADDR_BITS'(3);
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SIDE_COUNT = CFG_ADDR_BITS'(4);
    localparam logic [CFG_ADDR_BITS-1:0] CFG_OLD_WEIGHT = CFG_ADDR_BITS'(5);

    localparam logic [NUM_BITS-1:0]  RST_SIDE_NUM   = NUM_BITS'(322641);
    localparam logic [OFF_BITS-1:0]  RST_SIDE_OFF   = OFF_BITS'(315);
    localparam logic [NUM_BITS-1:0]  RST_FRONT_NUM  = NUM_BITS'(769533);
    localparam logic [OFF_BITS-1:0]  RST_FRONT_OFF  = OFF_BITS'(520);
    localparam logic [SCNT_BITS-1:0] RST_SIDE_COUNT = SCNT_BITS'(2);
    localparam logic [WGT_BITS-1:0]  RST_OLD_WEIGHT = WGT_BITS'(5);

    typedef logic [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic [NUM_BITS-1:0]  side_num;
        logic [OFF_BITS-1:0]  side_off;
        logic [NUM_BITS-1:0]  front_num;
        logic [OFF_BITS-1:0]  front_off;
        logic [SCNT_BITS-1:0] side_count;
        logic [WGT_BITS-1:0]  old_weight;
    } cfg_t;

    typedef struct packed {
        logic [IDX_BITS-1:0] idx;
        sample_t             mean;
    } q_item_t;

    typedef struct packed {
        logic [IDX_BITS-1:0] sensor;
        logic [NUM_BITS-1:0] distance;
        sample_t             level;
        logic                fault;
    } out_item_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SORT,
        F_MEAN
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SCALE,
        B_DIV,
        B_OUT
    } back_state_t;

endpackage

FILE: src/tmrs_front.sv
// Front end: takes an item, sorts its samples and forms the trimmed mean.
// Depends on tmrs_pkg; feeds tmrs_queue.
module tmrs_front (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  logic [tmrs_pkg::IDX_BITS-1:0]               in_idx,
    input  logic [tmrs_pkg::SAMPLE_COUNT-1:0][tmrs_pkg::SAMPLE_BITS-1:0] in_samples,
    output logic                                        q_push,
    output tmrs_pkg::q_item_t                           q_item,
    input  logic                                        q_full
);
    import tmrs_pkg::*;

    front_state_t               state_reg, state_next;
    logic [SORT_CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [IDX_BITS-1:0]        idx_reg, idx_next;
    sample_t                    vals_reg [SAMPLE_COUNT];
    sample_t                    vals_next [SAMPLE_COUNT];
    logic [SUM3_BITS-1:0]       sum3;
    logic [31:0]                mean_prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        vals_reg <= vals_next;
    end

    always_comb
    begin
        sum3 = SUM3_BITS'(vals_reg[MID_LOW]) + SUM3_BITS'(vals_reg[MID_LOW + 1])
             + SUM3_BITS'(vals_reg[MID_LOW + 2]);
        mean_prod = 32'(sum3) * 32'(DIV3_MUL);
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        vals_next  = vals_reg;
        in_ready   = 1'b0;
        q_push     = 1'b0;
        q_item.idx  = idx_reg;
        q_item.mean = mean_prod[DIV3_SHIFT +: SAMPLE_BITS];
        unique case (state_reg)
            F_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    idx_next = in_idx;
                    for (int i = 0; i < SAMPLE_COUNT; i++)
                    begin
                        vals_next[i] = in_samples[i];
                    end
                    cnt_next   = '0;
                    state_next = F_SORT;
                end
            end
            F_SORT:
            begin
                // one odd-even transposition pass per cycle
                for (int i = 0; i < SAMPLE_COUNT - 1; i++)
                begin
                    if ((i % 2) == int'(cnt_reg[0]) && vals_reg[i] > vals_reg[i + 1])
                    begin
                        vals_next[i]     = vals_reg[i + 1];
                        vals_next[i + 1] = vals_reg[i];
                    end
                end
                if (cnt_reg == SORT_CNT_BITS'(SAMPLE_COUNT - 1))
                begin
                    state_next = F_MEAN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            F_MEAN:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

endmodule

FILE: src/tmrs_queue.sv
// Short queue between front and back end, holding index and trimmed mean.
// Depends on tmrs_pkg.
module tmrs_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tmrs_pkg::q_item_t push_item,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output tmrs_pkg::q_item_t pop_item
);
    import tmrs_pkg::*;

    q_item_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_BITS-1:0]  count_reg;

    function automatic logic [QPTR_BITS-1:0] ptr_inc(input logic [QPTR_BITS-1:0] p);
        return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full     = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: src/tmrs_back.sv
// Back end: blends with the stored level, converts by serial division, holds the result.
// Depends on tmrs_pkg and the assertion macro header.
`include "trimmed_mean_range_sensor_filter_defines.svh"

module tmrs_back (
    input  logic                clk,
    input  logic                rst_n,
    input  tmrs_pkg::cfg_t      cfg,
    input  logic                q_valid,
    input  tmrs_pkg::q_item_t   q_item,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output tmrs_pkg::out_item_t out_item
);
    import tmrs_pkg::*;

    back_state_t               state_reg, state_next;
    logic [IDX_BITS-1:0]       idx_reg, idx_next;
    sample_t                   mean_reg, mean_next;
    logic [BLEND_BITS-1:0]     sum_reg, sum_next;
    logic                      old_zero_reg, old_zero_next;
    logic [NUM_BITS-1:0]       num_reg, num_next;
    logic [OFF_BITS-1:0]       off_reg, off_next;
    sample_t                   level_reg, level_next;
    logic [DIVW-1:0]           div_reg, div_next;
    logic [DIVW:0]             rem_reg, rem_next;
    logic [NUM_BITS-1:0]       quo_reg, quo_next;
    logic [DIV_CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                      fault_reg, fault_next;
    logic                      out_valid_reg, out_valid_next;
    out_item_t                 out_reg, out_next;
    sample_t                   store_reg [SENSOR_COUNT];

    logic                      store_we;
    sample_t                   old_level;
    logic [WGT_BITS-1:0]       weight;
    logic                      is_side;
    logic [31:0]               scale_prod;
    logic [DEN_BITS-1:0]       den;
    logic [DIVW:0]             rem_sh;

    function automatic logic in_store(input logic [IDX_BITS-1:0] i);
        return 32'(i) < 32'(SENSOR_COUNT);
    endfunction

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SENSOR_COUNT; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (store_we)
        begin
            store_reg[STORE_IDX_BITS'(idx_reg)] <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        mean_reg     <= mean_next;
        sum_reg      <= sum_next;
        old_zero_reg <= old_zero_next;
        num_reg      <= num_next;
        off_reg      <= off_next;
        level_reg    <= level_next;
        div_reg      <= div_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        fault_reg    <= fault_next;
        out_reg      <= out_next;
    end

    always_comb
    begin
        old_level  = in_store(q_item.idx) ? store_reg[STORE_IDX_BITS'(q_item.idx)] : '0;
        weight     = (cfg.old_weight > WEIGHT_FULL) ? WEIGHT_FULL : cfg.old_weight;
        is_side    = ({1'b0, q_item.idx} < cfg.side_count);
        scale_prod = 32'(sum_reg) * 32'(DIV10_MUL);
        den        = {{(DEN_BITS - SAMPLE_BITS - 4){1'b0}}, level_next, 4'b0000}
                   - DEN_BITS'(off_reg);
        rem_sh     = {rem_reg[DIVW-1:0], quo_reg[NUM_BITS-1]};
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        mean_next      = mean_reg;
        sum_next       = sum_reg;
        old_zero_next  = old_zero_reg;
        num_next       = num_reg;
        off_next       = off_reg;
        level_next     = level_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        fault_next     = fault_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        q_pop          = 1'b0;
        store_we       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop         = 1'b1;
                    idx_next      = q_item.idx;
                    mean_next     = q_item.mean;
                    old_zero_next = (old_level == '0);
                    sum_next      = BLEND_BITS'(weight) * BLEND_BITS'(old_level)
                                  + BLEND_BITS'(WEIGHT_FULL - weight)
                                  * BLEND_BITS'(q_item.mean);
                    num_next      = is_side ? cfg.side_num : cfg.front_num;
                    off_next      = is_side ? cfg.side_off : cfg.front_off;
                    state_next    = B_SCALE;
                end
            end
            B_SCALE:
            begin
                level_next = old_zero_reg ? mean_reg : scale_prod[DIV10_SHIFT +: SAMPLE_BITS];
                store_we   = in_store(idx_reg);
                fault_next = den[DEN_BITS-1] || (den == '0);
                div_next   = den[DIVW-1:0];
                rem_next   = '0;
                quo_next   = num_reg;
                cnt_next   = DIV_CNT_BITS'(NUM_BITS - 1);
                state_next = (den[DEN_BITS-1] || (den == '0)) ? B_OUT : B_DIV;
            end
            B_DIV:
            begin
                // one restoring quotient bit per cycle
                if (rem_sh >= {1'b0, div_reg})
                begin
                    rem_next = rem_sh - {1'b0, div_reg};
                    quo_next = {quo_reg[NUM_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[NUM_BITS-2:0], 1'b0};
                end
                if (cnt_reg == '0)
                begin
                    state_next = B_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            B_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.sensor   = idx_reg;
                    out_next.distance = fault_reg ? '0 : quo_reg;
                    out_next.level    = level_reg;
                    out_next.fault    = fault_reg;
                    out_valid_next    = 1'b1;
                    state_next        = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    `TMRS_ASSERT_NOW(a_fault_zero_distance, out_valid_reg && out_reg.fault, out_reg.distance == '0, "faulted result carries a nonzero distance")
    `TMRS_ASSERT_NOW(a_div_without_fault, state_reg == B_DIV, !fault_reg, "divider running on a faulted item")
    `TMRS_ASSERT_NEXT(a_div_finishes, state_reg == B_DIV && cnt_reg == '0, state_reg == B_OUT, "divider did not hand over after its last step")

endmodule

FILE: src/trimmed_mean_range_sensor_filter.sv
// The 20-step serial divider in the back end limits the item rate; on a denominator
// fault it is skipped. The front end takes the next item meanwhile while the queue
// has room, and overlaps with the back end through the two-entry queue.
// Reset (rst_n low, asynchronous): configuration registers return to their defaults,
// all stored levels clear to zero, queue and output empty.
// Top level: configuration registers and stream port packing; uses tmrs_pkg and submodules.
module trimmed_mean_range_sensor_filter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // sample_a, sample_b, sample_c, sample_d, sample_e, sample_f, sample_g, zero fill
    input  logic [tmrs_pkg::S_DATA_BITS-1:0]     s_axis_tdata,
    // sensor_index
    input  logic [tmrs_pkg::IDX_BITS-1:0]        s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // distance, smoothed_level, zero fill
    output logic [tmrs_pkg::M_DATA_BITS-1:0]     m_axis_tdata,
    // result_sensor, denominator_fault
    output logic [tmrs_pkg::M_USER_BITS-1:0]     m_axis_tuser,
    input  logic                                 cfg_we,
    input  logic [tmrs_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  logic [tmrs_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
    import tmrs_pkg::*;

    cfg_t       cfg_reg;
    logic [SAMPLE_COUNT-1:0][SAMPLE_BITS-1:0] samples;
    logic       q_push, q_full, q_pop, q_valid;
    q_item_t    q_push_item, q_pop_item;
    out_item_t  out_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.side_num   <= RST_SIDE_NUM;
            cfg_reg.side_off   <= RST_SIDE_OFF;
            cfg_reg.front_num  <= RST_FRONT_NUM;
            cfg_reg.front_off  <= RST_FRONT_OFF;
            cfg_reg.side_count <= RST_SIDE_COUNT;
            cfg_reg.old_weight <= RST_OLD_WEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_SIDE_NUM:   cfg_reg.side_num   <= cfg_wdata[NUM_BITS-1:0];
                CFG_SIDE_OFF:   cfg_reg.side_off   <= cfg_wdata[OFF_BITS-1:0];
                CFG_FRONT_NUM:  cfg_reg.front_num  <= cfg_wdata[NUM_BITS-1:0];
                CFG_FRONT_OFF:  cfg_reg.front_off  <= cfg_wdata[OFF_BITS-1:0];
                CFG_SIDE_COUNT: cfg_reg.side_count <= cfg_wdata[SCNT_BITS-1:0];
                CFG_OLD_WEIGHT: cfg_reg.old_weight <= cfg_wdata[WGT_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < SAMPLE_COUNT; i++)
        begin
            samples[i] = s_axis_tdata[i * SAMPLE_BITS +: SAMPLE_BITS];
        end
    end

    tmrs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_idx     (s_axis_tuser),
        .in_samples (samples),
        .q_push     (q_push),
        .q_item     (q_push_item),
        .q_full     (q_full)
    );

    tmrs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_item  (q_pop_item)
    );

    tmrs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_pop_item),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (out_item)
    );

    assign m_axis_tdata = {{(M_DATA_BITS - NUM_BITS - SAMPLE_BITS){1'b0}},
                           out_item.level, out_item.distance};
    assign m_axis_tuser = {out_item.fault, out_item.sensor};

endmodule
